>>> src/bhvs_pkg.sv
// Shared constants and types for the bitstate hash visited-set core.
package bhvs_pkg;

    // Table size in bytes; must be a power of two (8 * TABLE_BYTES bits).
    localparam int TABLE_BYTES = 4096;
    localparam int TABLE_BITS  = TABLE_BYTES * 8;
    localparam int HASH_W      = $clog2(TABLE_BITS);

    // Result address field width.
    localparam int ADDR_W  = 15;
    localparam int COUNT_W = 32;

    // Hash constants.
    localparam logic [63:0] HASH_SEED = 64'd19;
    localparam logic [63:0] ZERO_MUL  = 64'd99277;
    localparam logic [63:0] ADD_KEY   = 64'd104729;
    localparam logic [63:0] BYTE_MUL  = 64'd57193;

    // Bitmap RAM organization: rows of ROW_BITS bits.
    localparam int ROW_BITS = (TABLE_BITS < 32) ? TABLE_BITS : 32;
    localparam int BIT_W    = $clog2(ROW_BITS);
    localparam int ROWS     = TABLE_BITS / ROW_BITS;
    localparam int ROW_AW   = (ROWS > 1) ? $clog2(ROWS) : 1;

    // Probe queue between front and back.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [HASH_W-1:0] addr;
    } probe_req_t;

    typedef struct packed {
        logic       push;
        probe_req_t req;
    } front_push_t;

endpackage

>>> src/bhvs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bhvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/bhvs_hash_front.sv
// Front end: running byte hash, emits one probe request per finished state.
module bhvs_hash_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           state_byte,
    input  logic                 last_byte,
    input  logic                 empty_state,
    output bhvs_pkg::front_push_t push
);

    localparam logic [bhvs_pkg::HASH_W-1:0] SEED_W =
        bhvs_pkg::HASH_W'(bhvs_pkg::HASH_SEED);
    localparam logic [bhvs_pkg::HASH_W-1:0] ZMUL_W =
        bhvs_pkg::HASH_W'(bhvs_pkg::ZERO_MUL);
    localparam logic [bhvs_pkg::HASH_W-1:0] KEY_W =
        bhvs_pkg::HASH_W'(bhvs_pkg::ADD_KEY);
    localparam logic [bhvs_pkg::HASH_W-1:0] BMUL_W =
        bhvs_pkg::HASH_W'(bhvs_pkg::BYTE_MUL);

    // Only the low HASH_W bits of the 64-bit wrapping hash reach the address.
    logic [bhvs_pkg::HASH_W-1:0] hash_reg;
    logic [bhvs_pkg::HASH_W-1:0] hash_next;
    logic [bhvs_pkg::HASH_W-1:0] mul_a;
    logic [bhvs_pkg::HASH_W-1:0] mul_b;
    logic [bhvs_pkg::HASH_W-1:0] upd;

    always_comb
    begin
        if (state_byte == 8'd0)
        begin
            mul_a = hash_reg;
            mul_b = ZMUL_W;
        end
        else
        begin
            mul_a = hash_reg + (KEY_W ^ bhvs_pkg::HASH_W'(state_byte));
            mul_b = BMUL_W;
        end
        upd = bhvs_pkg::HASH_W'(mul_a * mul_b);

        hash_next     = hash_reg;
        push.push     = 1'b0;
        push.req.addr = upd;
        if (accept)
        begin
            if (empty_state)
            begin
                push.push     = 1'b1;
                push.req.addr = '0;
                hash_next     = SEED_W;
            end
            else if (last_byte)
            begin
                push.push = 1'b1;
                hash_next = SEED_W;
            end
            else
            begin
                hash_next = upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= SEED_W;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

endmodule

>>> src/bhvs_fifo.sv
// Short probe queue between the hash front end and the probe back end.
module bhvs_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bhvs_pkg::front_push_t push,
    input  logic                 pop,
    output logic                 head_valid,
    output bhvs_pkg::probe_req_t head,
    output logic                 full
);

    bhvs_pkg::probe_req_t          entry_reg [bhvs_pkg::FIFO_DEPTH];
    logic [bhvs_pkg::FIFO_AW-1:0]  wr_ptr_reg;
    logic [bhvs_pkg::FIFO_AW-1:0]  rd_ptr_reg;
    logic [bhvs_pkg::FIFO_AW:0]    count_reg;
    logic [bhvs_pkg::FIFO_AW:0]    count_next;
    logic                          do_push;
    logic                          do_pop;

    assign full       = (count_reg == (bhvs_pkg::FIFO_AW+1)'(bhvs_pkg::FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push.push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

>>> src/bhvs_probe_back.sv
// Back end: bitmap clear after reset, test-and-set probe, hit counter, output word.
module bhvs_probe_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    input  bhvs_pkg::probe_req_t                req,
    output logic                                pop,
    output logic                                clearing,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                seen,
    output logic [bhvs_pkg::ADDR_W-1:0]         bit_address,
    output logic [bhvs_pkg::COUNT_W-1:0]        collision_count
);

    localparam logic [bhvs_pkg::ROW_AW-1:0] LAST_ROW =
        bhvs_pkg::ROW_AW'(bhvs_pkg::ROWS - 1);

    logic                               clear_reg;
    logic [bhvs_pkg::ROW_AW-1:0]        clr_row_reg;
    logic                               s1_valid_reg;
    logic [bhvs_pkg::HASH_W-1:0]        s1_addr_reg;
    logic                               fwd_valid_reg;
    logic [bhvs_pkg::ROW_AW-1:0]        fwd_row_reg;
    logic [bhvs_pkg::ROW_BITS-1:0]      fwd_data_reg;
    logic [bhvs_pkg::COUNT_W-1:0]       hit_cnt_reg;
    logic [bhvs_pkg::COUNT_W-1:0]       hit_cnt_next;
    logic                               out_valid_reg;
    logic                               seen_reg;
    logic [bhvs_pkg::ADDR_W-1:0]        addr_reg;
    logic [bhvs_pkg::COUNT_W-1:0]       count_reg;

    logic                               s1_fire;
    logic [bhvs_pkg::ROW_AW-1:0]        s1_row;
    logic [bhvs_pkg::BIT_W-1:0]         s1_bit;
    logic [bhvs_pkg::ROW_BITS-1:0]      rd_data;
    logic [bhvs_pkg::ROW_BITS-1:0]      cur_row;
    logic [bhvs_pkg::ROW_BITS-1:0]      bit_mask;
    logic [bhvs_pkg::ROW_BITS-1:0]      new_row;
    logic                               hit;
    logic                               ram_we;
    logic [bhvs_pkg::ROW_AW-1:0]        ram_waddr;
    logic [bhvs_pkg::ROW_BITS-1:0]      ram_wdata;
    logic [bhvs_pkg::ROW_AW-1:0]        ram_raddr;

    assign s1_row   = bhvs_pkg::ROW_AW'(s1_addr_reg >> bhvs_pkg::BIT_W);
    assign s1_bit   = bhvs_pkg::BIT_W'(s1_addr_reg);
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign pop      = req_valid && !clear_reg && (!s1_valid_reg || s1_fire);
    assign ram_raddr = bhvs_pkg::ROW_AW'(req.addr >> bhvs_pkg::BIT_W);

    // Row written in the same cycle as this row's read is not in rd_data yet.
    assign cur_row  = (fwd_valid_reg && fwd_row_reg == s1_row) ? fwd_data_reg : rd_data;
    assign bit_mask = bhvs_pkg::ROW_BITS'(1) << s1_bit;
    assign hit      = |(cur_row & bit_mask);
    assign new_row  = cur_row | bit_mask;

    always_comb
    begin
        hit_cnt_next = hit_cnt_reg;
        if (hit && hit_cnt_reg != '1)
        begin
            hit_cnt_next = hit_cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        if (clear_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_row_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = s1_fire;
            ram_waddr = s1_row;
            ram_wdata = new_row;
        end
    end

    bhvs_ram #(
        .WIDTH (bhvs_pkg::ROW_BITS),
        .DEPTH (bhvs_pkg::ROWS)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (pop),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg     <= 1'b1;
            clr_row_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            hit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear_reg)
            begin
                clr_row_reg <= clr_row_reg + 1'b1;
                if (clr_row_reg == LAST_ROW)
                begin
                    clear_reg <= 1'b0;
                end
            end
            if (pop)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                fwd_valid_reg <= 1'b1;
                hit_cnt_reg   <= hit_cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_addr_reg <= req.addr;
        end
        if (s1_fire)
        begin
            fwd_row_reg  <= s1_row;
            fwd_data_reg <= new_row;
            seen_reg     <= hit;
            addr_reg     <= bhvs_pkg::ADDR_W'(s1_addr_reg);
            count_reg    <= hit_cnt_next;
        end
    end

    assign clearing        = clear_reg;
    assign out_valid       = out_valid_reg;
    assign seen            = seen_reg;
    assign bit_address     = addr_reg;
    assign collision_count = count_reg;

`ifndef SYNTHESIS
    a_no_probe_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear_reg |-> (!pop && !s1_valid_reg && ram_wdata == '0))
        else $error("probe issued during bitmap clear");

    a_fire_sets_bit: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |-> (ram_we && (ram_wdata & bit_mask) != '0))
        else $error("probe did not set its bit");

    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(clear_reg) |-> hit_cnt_reg >= $past(hit_cnt_reg))
        else $error("hit counter decreased");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_fire |=> $stable(hit_cnt_reg))
        else $error("hit counter moved without a probe");

    a_out_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> (out_valid_reg && collision_count == hit_cnt_reg))
        else $error("result word does not match counter");
`endif

endmodule

>>> src/bitstate_hash_visited_set_core.sv
// Top level of the bitstate hash visited-set core.
//
// Input channel (in_valid/in_ready): one state byte per word, last_byte marks
// the final byte of a state; empty_state sends the state straight to bit 0.
// Output channel (out_valid/out_ready): one word per finished state with seen,
// bit_address and the saturating collision_count after this check.
// Throughput: one input word per cycle while in_ready is high. The result
// word for a state is registered in the probe queue, then leaves it with the
// bitmap row read into the probe stage, then the test-and-set updates the
// row and loads the output register.
// Reset: the running hash returns to 19, the hit count to zero, and the
// bitmap RAM is swept to zero one 32-bit row per cycle, all 1024 rows
// (8 * TABLE_BYTES / 32); in_ready stays low during the sweep.
// Receiver stall: the output register holds its word, the probe stage and the
// 4-entry probe queue fill, then in_ready drops; nothing is lost.
module bitstate_hash_visited_set_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     state_byte,
    input  logic                           last_byte,
    input  logic                           empty_state,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           seen,
    output logic [bhvs_pkg::ADDR_W-1:0]    bit_address,
    output logic [bhvs_pkg::COUNT_W-1:0]   collision_count
);

    bhvs_pkg::front_push_t push;
    bhvs_pkg::probe_req_t  head;
    logic                  head_valid;
    logic                  fifo_full;
    logic                  pop;
    logic                  clearing;
    logic                  accept;

    assign in_ready = !clearing && !fifo_full;
    assign accept   = in_valid && in_ready;

    bhvs_hash_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .state_byte  (state_byte),
        .last_byte   (last_byte),
        .empty_state (empty_state),
        .push        (push)
    );

    bhvs_fifo u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .full       (fifo_full)
    );

    bhvs_probe_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (head_valid),
        .req             (head),
        .pop             (pop),
        .clearing        (clearing),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .seen            (seen),
        .bit_address     (bit_address),
        .collision_count (collision_count)
    );

endmodule

>>> tb/tb.sv
// Self-checking testbench for the bitstate hash visited-set core.
`timescale 1ns / 100ps

module tb;

    localparam int RANDOM_WORDS = 750;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        logic [7:0]                   b;
        logic                         last;
        logic                         empty;
        logic                         chk;
        logic                         sn;
        logic [bhvs_pkg::ADDR_W-1:0]  ad;
        logic [bhvs_pkg::COUNT_W-1:0] cnt;
    } stim_word_t;

    typedef struct packed {
        logic                         seen;
        logic [bhvs_pkg::ADDR_W-1:0]  addr;
        logic [bhvs_pkg::COUNT_W-1:0] count;
    } probe_out_t;

    typedef struct {
        int start;
        int len;
    } state_span_t;

    // byte, last, empty, typed check, seen, address, count
    localparam stim_word_t DIRECTED [0:21] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 15'd0, 32'd0},
        '{8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 15'd0, 32'd1},
        '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 15'd0, 32'd0},
        '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 15'd0, 32'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 15'd0, 32'd0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 15'd0, 32'd0},
        '{8'h01, 1'b1, 1'b0, 1'b0, 1'b0, 15'd0, 32'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 15'd0, 32'd0},
        '{8'h80, 1'b0, 1'b0, 1'b0, 1'b0, 15'd0, 32'd0},
        '{8'h7F, 1'b0, 1'b1, 1'b0, 1'b0, 15'd0, 32'd0},
        '{8'hAA, 1'b1, 1'b0, 1'b0, 1'b0, 15'd0, 32'd0},
        '{8'h55, 1'b1, 1'b0, 1'b0, 1'b0, 15'd0, 32'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 15'd0, 32'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 15'd0, 32'd0},
        '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 15'd0, 32'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 15'd0, 32'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 15'd0, 32'd0},
        '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 15'd0, 32'd0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 15'd0, 32'd0},
        '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 15'd0, 32'd0},
        '{8'h01, 1'b0, 1'b0, 1'b0, 1'b0, 15'd0, 32'd0},
        '{8'hFE, 1'b1, 1'b0, 1'b0, 1'b0, 15'd0, 32'd0}
    };

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [7:0]                   state_byte = 8'h00;
    logic                         last_byte = 1'b0;
    logic                         empty_state = 1'b0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic                         seen;
    logic [bhvs_pkg::ADDR_W-1:0]  bit_address;
    logic [bhvs_pkg::COUNT_W-1:0] collision_count;

    stim_word_t   stim_q[$];
    probe_out_t   pending_results[$];
    logic [63:0]  hash_acc = bhvs_pkg::HASH_SEED;
    bit           visited_map [bhvs_pkg::TABLE_BITS];
    logic [31:0]  hit_total = '0;
    int           words_taken = 0;
    int           fail_count = 0;
    bit           calm_tail = 1'b0;

    bitstate_hash_visited_set_core u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .state_byte      (state_byte),
        .last_byte       (last_byte),
        .empty_state     (empty_state),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .seen            (seen),
        .bit_address     (bit_address),
        .collision_count (collision_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Fold one accepted word into the running hash; test-and-set on a finished state.
    task automatic fold_word(input stim_word_t w);
        logic [63:0] slot;
        logic        do_probe;
        probe_out_t  r;
        slot = '0;
        do_probe = 1'b1;
        if (w.empty)
            hash_acc = bhvs_pkg::HASH_SEED;
        else
        begin
            if (w.b == 8'h00)
                hash_acc = hash_acc * bhvs_pkg::ZERO_MUL;
            else
                hash_acc = (hash_acc + (bhvs_pkg::ADD_KEY ^ {56'd0, w.b}))
                           * bhvs_pkg::BYTE_MUL;
            do_probe = w.last;
            if (w.last)
            begin
                slot = hash_acc % 64'(bhvs_pkg::TABLE_BITS);
                hash_acc = bhvs_pkg::HASH_SEED;
            end
        end
        if (do_probe)
        begin
            r.seen = visited_map[slot];
            if (r.seen)
            begin
                if (hit_total != '1)
                    hit_total = hit_total + 32'd1;
            end
            else
                visited_map[slot] = 1'b1;
            r.addr  = slot[bhvs_pkg::ADDR_W-1:0];
            r.count = hit_total;
            if (w.chk)
            begin
                r.seen  = w.sn;
                r.addr  = w.ad;
                r.count = w.cnt;
            end
            pending_results.push_back(r);
        end
    endtask

    function automatic stim_word_t plain_word(input logic [7:0] b, input logic last,
                                              input logic empty);
        stim_word_t w;
        w = '0;
        w.b = b;
        w.last = last;
        w.empty = empty;
        return w;
    endfunction

    function automatic logic [7:0] rand_byte();
        if ($urandom_range(0, 4) == 0)
            return 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly well-formed states, some replayed for hits, plus empties and broken states.
    task automatic build_random();
        state_span_t done_states[$];
        state_span_t span;
        int          n;
        int          len;
        int          pick;
        int          base;
        n = 0;
        while (n < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75 && pick >= 55 && done_states.size() > 0)
            begin
                span = done_states[$urandom_range(0, done_states.size() - 1)];
                for (int k = 0; k < span.len; k++)
                    stim_q.push_back(stim_q[span.start + k]);
                n += span.len;
            end
            else if (pick < 75)
            begin
                len = $urandom_range(1, 8);
                base = stim_q.size();
                for (int k = 0; k < len; k++)
                    stim_q.push_back(plain_word(rand_byte(), k == len - 1, 1'b0));
                span.start = base;
                span.len = len;
                done_states.push_back(span);
                n += len;
            end
            else if (pick < 85)
            begin
                stim_q.push_back(plain_word(8'($urandom_range(0, 255)),
                                            1'($urandom_range(0, 1)), 1'b1));
                n += 1;
            end
            else if (pick < 95)
            begin
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++)
                    stim_q.push_back(plain_word(rand_byte(), 1'b0, 1'b0));
                stim_q.push_back(plain_word(8'($urandom_range(0, 255)),
                                            1'($urandom_range(0, 1)), 1'b1));
                n += len + 1;
            end
            else
            begin
                stim_q.push_back(plain_word(8'($urandom_range(0, 255)), 1'b1, 1'b0));
                n += 1;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            fold_word(stim_q[words_taken]);
            words_taken <= words_taken + 1;
        end
    end

    always @(posedge clk)
    begin : result_check
        probe_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result word: seen %0d addr %0d count %0d",
                       seen, bit_address, collision_count);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (seen !== want.seen)
                begin
                    $error("seen: expected %0d, got %0d", want.seen, seen);
                    fail_count++;
                end
                if (bit_address !== want.addr)
                begin
                    $error("bit_address: expected %0d, got %0d", want.addr, bit_address);
                    fail_count++;
                end
                if (collision_count !== want.count)
                begin
                    $error("collision_count: expected %0d, got %0d",
                           want.count, collision_count);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: random stall bursts, one long hold-off to back up the input.
    initial
    begin : receiver
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && words_taken >= HOLD_AT)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_ready <= 1'b1;
            end
            else if (!calm_tail && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : sender
        for (int i = 0; i < $size(DIRECTED); i++)
            stim_q.push_back(DIRECTED[i]);
        build_random();
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < stim_q.size(); i++)
        begin
            @(negedge clk);
            if (i >= (stim_q.size() * 9) / 10)
                calm_tail = 1'b1;
            if (!calm_tail && $urandom_range(0, 4) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
            in_valid    <= 1'b1;
            state_byte  <= stim_q[i].b;
            last_byte   <= stim_q[i].last;
            empty_state <= stim_q[i].empty;
            do
                @(posedge clk);
            while (!in_ready);
        end
        @(negedge clk);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
